@@ hdl/tsg_pkg.sv @@
// Shared types and constants of the TGA stream to greyscale decoder.
package tsg_pkg;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Register index, taken from paddr[2].
    localparam logic REG_FIRST_ROW = 1'b0;
    localparam logic REG_END_ROW   = 1'b1;

    localparam logic [15:0] FIRST_ROW_RESET = 16'd0;
    localparam logic [15:0] END_ROW_RESET   = 16'hffff;

    // Header layout.
    localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_DEPTH     = 5'd16;
    localparam logic [4:0] HDR_FLAGS     = 5'd17;

    localparam logic [7:0] DEPTH_GREY = 8'd8;
    localparam logic [7:0] DEPTH_BGR  = 8'd24;

    localparam int FLAG_TOP_BIT    = 5;
    localparam int FLAG_IL_LSB     = 6;
    localparam logic [1:0] IL_NONE = 2'd0;
    localparam logic [1:0] IL_TWO  = 2'd1;
    localparam logic [1:0] IL_FOUR = 2'd2;

    // Status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TRUNCATED = 3'd1;
    localparam logic [2:0] ST_TOO_SHORT = 3'd2;
    localparam logic [2:0] ST_REVERSED  = 3'd3;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd4;
    localparam logic [2:0] ST_BAD_DEPTH = 3'd5;
    localparam logic [2:0] ST_INTERLACE = 3'd6;

    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_SKIP   = 2'd1,
        PH_DATA   = 2'd2,
        PH_DRAIN  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } byte_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  grey_value;
        logic [15:0] pixel_column;
        logic [15:0] pixel_row;
        logic [2:0]  status_code;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        last_result;
    } result_t;

    typedef struct packed {
        logic [15:0] first_row;
        logic [15:0] end_row;
    } cfg_t;

    // Up to two results per byte; when one, it sits in first.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

@@ hdl/tsg_config.sv @@
// APB-style register file holding the row window.
module tsg_config (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tsg_pkg::ADDR_W-1:0] paddr,
    input  logic [tsg_pkg::DATA_W-1:0] pwdata,
    output logic [tsg_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output tsg_pkg::cfg_t              cfg
);

    logic [15:0] first_row_reg;
    logic [15:0] end_row_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_row_reg <= tsg_pkg::FIRST_ROW_RESET;
            end_row_reg   <= tsg_pkg::END_ROW_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                tsg_pkg::REG_FIRST_ROW: first_row_reg <= pwdata[15:0];
                tsg_pkg::REG_END_ROW:   end_row_reg   <= pwdata[15:0];
                default:                first_row_reg <= first_row_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            tsg_pkg::REG_FIRST_ROW: prdata = {16'd0, first_row_reg};
            tsg_pkg::REG_END_ROW:   prdata = {16'd0, end_row_reg};
            default:                prdata = '0;
        endcase
    end

    assign cfg.first_row = first_row_reg;
    assign cfg.end_row   = end_row_reg;

endmodule

@@ hdl/tsg_decoder.sv @@
// Header parser, row window control and greyscale pixel datapath.
module tsg_decoder (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  tsg_pkg::byte_t req,
    input  tsg_pkg::cfg_t  cfg,
    output tsg_pkg::push_t push
);

    tsg_pkg::phase_t phase_reg, phase_next, phase_after;
    logic [4:0]  hdr_count_reg, hdr_count_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic        three_reg, three_next;
    logic        top_reg, top_next;
    logic [1:0]  il_reg, il_next;
    logic        depth_bad_reg, depth_bad_next;
    logic [15:0] rows_reg, rows_next;
    logic [15:0] skip_reg, skip_next;
    logic [15:0] out_row_reg, out_row_next;
    logic [15:0] col_reg, col_next;
    logic [1:0]  bip_reg, bip_next;
    logic [7:0]  blue_reg, blue_next;
    logic [7:0]  green_reg, green_next;

    logic [7:0]  b;
    logic        eof;
    logic        hdr_last;
    logic [15:0] rs, re;
    logic        partial;
    logic        flag_top;
    logic [1:0]  flag_il;
    logic [2:0]  hdr_code;
    logic        hdr_done;
    logic        bip_wrap;
    logic        col_wrap;
    logic        row_done;
    logic        data_finish;
    logic [12:0] grey_sum;

    tsg_pkg::result_t pix, stat;
    logic        pix_valid, stat_valid;

    // Output row after interlace mapping and bottom-origin flip, modulo 2^16.
    function automatic logic [15:0] map_row(input logic [15:0] i, input logic [15:0] h,
                                            input logic [1:0] il, input logic top);
        logic [17:0] three_h;
        logic [15:0] q1, q2, q3, d, row;
        three_h = {2'b00, h} + {1'b0, h, 1'b0};
        q1 = {2'b00, h[15:2]};
        q2 = {1'b0, h[15:1]};
        q3 = three_h[17:2];
        if (il == tsg_pkg::IL_FOUR)
        begin
            if (i < q1)
            begin
                row = {i[13:0], 2'b00};
            end
            else if (i < q2)
            begin
                d   = i - q1;
                row = {d[13:0], 2'b01};
            end
            else if (i < q3)
            begin
                d   = i - q2;
                row = {d[13:0], 2'b10};
            end
            else
            begin
                d   = i - q3;
                row = {d[13:0], 2'b11};
            end
        end
        else if (il == tsg_pkg::IL_TWO)
        begin
            if (i < q2)
            begin
                row = {i[14:0], 1'b0};
            end
            else
            begin
                d   = i - q2;
                row = {d[14:0], 1'b1};
            end
        end
        else
        begin
            row = i;
        end
        if (!top)
        begin
            row = h - row - 16'd1;
        end
        return row;
    endfunction

    assign b   = req.data_byte;
    assign eof = req.end_of_file;

    // Header decisions, evaluated on the flags byte.
    assign hdr_last = (hdr_count_reg == tsg_pkg::HDR_FLAGS);
    assign rs       = (cfg.first_row > height_reg) ? height_reg : cfg.first_row;
    assign re       = (cfg.end_row > height_reg) ? height_reg : cfg.end_row;
    assign partial  = (rs != 16'd0) || (re < height_reg);
    assign flag_top = b[tsg_pkg::FLAG_TOP_BIT];
    assign flag_il  = b[tsg_pkg::FLAG_IL_LSB +: 2];

    always_comb
    begin
        if (cfg.first_row > cfg.end_row)
        begin
            hdr_code = tsg_pkg::ST_REVERSED;
        end
        else if ((width_reg < 16'd2) || (height_reg < 16'd2))
        begin
            hdr_code = tsg_pkg::ST_BAD_SIZE;
        end
        else if (depth_bad_reg)
        begin
            hdr_code = tsg_pkg::ST_BAD_DEPTH;
        end
        else if (((flag_il != tsg_pkg::IL_NONE) && (partial || !flag_top))
                 || (partial && !flag_top))
        begin
            hdr_code = tsg_pkg::ST_INTERLACE;
        end
        else
        begin
            hdr_code = tsg_pkg::ST_OK;
        end
    end

    assign hdr_done = (hdr_code != tsg_pkg::ST_OK) || (re == rs);

    // Byte and column counters.
    assign bip_wrap    = !three_reg || (bip_reg == 2'd2);
    assign col_wrap    = ({1'b0, col_reg} + 17'd1) >= {1'b0, width_reg};
    assign row_done    = bip_wrap && col_wrap;
    assign data_finish = row_done && (({1'b0, out_row_reg} + 17'd1) >= {1'b0, rows_reg});

    assign grey_sum = 13'(b) * 13'd11 + {1'b0, green_reg, 4'b0000}
                    + 13'(blue_reg) * 13'd5;

    // Next phase, before end of file is applied.
    always_comb
    begin
        phase_after = phase_reg;
        unique case (phase_reg)
            tsg_pkg::PH_HEADER:
            begin
                if (hdr_last)
                begin
                    if (hdr_done)
                        phase_after = tsg_pkg::PH_DRAIN;
                    else if (rs != 16'd0)
                        phase_after = tsg_pkg::PH_SKIP;
                    else
                        phase_after = tsg_pkg::PH_DATA;
                end
            end
            tsg_pkg::PH_SKIP:
            begin
                if (row_done && (skip_reg == 16'd1))
                    phase_after = tsg_pkg::PH_DATA;
            end
            tsg_pkg::PH_DATA:
            begin
                if (data_finish)
                    phase_after = tsg_pkg::PH_DRAIN;
            end
            tsg_pkg::PH_DRAIN:
            begin
                phase_after = tsg_pkg::PH_DRAIN;
            end
            default:
            begin
                phase_after = tsg_pkg::PH_HEADER;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        phase_next     = phase_reg;
        hdr_count_next = hdr_count_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        three_next     = three_reg;
        top_next       = top_reg;
        il_next        = il_reg;
        depth_bad_next = depth_bad_reg;
        rows_next      = rows_reg;
        skip_next      = skip_reg;
        out_row_next   = out_row_reg;
        col_next       = col_reg;
        bip_next       = bip_reg;
        blue_next      = blue_reg;
        green_next     = green_reg;
        if (accept)
        begin
            phase_next = phase_after;
            if (phase_reg == tsg_pkg::PH_HEADER)
            begin
                if (hdr_count_reg == tsg_pkg::HDR_WIDTH_LO)
                    width_next = {8'd0, b};
                if (hdr_count_reg == tsg_pkg::HDR_WIDTH_HI)
                    width_next = {b, width_reg[7:0]};
                if (hdr_count_reg == tsg_pkg::HDR_HEIGHT_LO)
                    height_next = {8'd0, b};
                if (hdr_count_reg == tsg_pkg::HDR_HEIGHT_HI)
                    height_next = {b, height_reg[7:0]};
                if (hdr_count_reg == tsg_pkg::HDR_DEPTH)
                begin
                    three_next     = (b == tsg_pkg::DEPTH_BGR);
                    depth_bad_next = (b != tsg_pkg::DEPTH_BGR) && (b != tsg_pkg::DEPTH_GREY);
                end
                if (hdr_last)
                begin
                    top_next = flag_top;
                    il_next  = flag_il;
                    if (hdr_code == tsg_pkg::ST_OK)
                    begin
                        rows_next = re - rs;
                        skip_next = rs;
                    end
                end
                else
                begin
                    hdr_count_next = hdr_count_reg + 5'd1;
                end
            end
            if ((phase_reg == tsg_pkg::PH_SKIP) || (phase_reg == tsg_pkg::PH_DATA))
            begin
                bip_next = bip_wrap ? 2'd0 : bip_reg + 2'd1;
                if (bip_wrap)
                    col_next = col_wrap ? 16'd0 : col_reg + 16'd1;
            end
            if ((phase_reg == tsg_pkg::PH_SKIP) && row_done)
                skip_next = skip_reg - 16'd1;
            if (phase_reg == tsg_pkg::PH_DATA)
            begin
                if (three_reg && (bip_reg == 2'd0))
                    blue_next = b;
                if (three_reg && (bip_reg == 2'd1))
                    green_next = b;
                if (row_done)
                    out_row_next = out_row_reg + 16'd1;
            end
            if (eof)
            begin
                // The last byte of a file always returns to header parsing.
                phase_next     = tsg_pkg::PH_HEADER;
                hdr_count_next = '0;
                width_next     = '0;
                height_next    = '0;
                three_next     = 1'b0;
                top_next       = 1'b0;
                il_next        = tsg_pkg::IL_NONE;
                depth_bad_next = 1'b0;
                rows_next      = '0;
                skip_next      = '0;
                out_row_next   = '0;
                col_next       = '0;
                bip_next       = '0;
                blue_next      = '0;
                green_next     = '0;
            end
        end
    end

    // Results of the accepted byte.
    always_comb
    begin
        pix_valid = accept && (phase_reg == tsg_pkg::PH_DATA) && bip_wrap;
        pix.result_kind  = tsg_pkg::KIND_PIXEL;
        pix.grey_value   = three_reg ? grey_sum[12:5] : b;
        pix.pixel_column = col_reg;
        pix.pixel_row    = map_row(out_row_reg, height_reg, il_reg, top_reg);
        pix.status_code  = tsg_pkg::ST_OK;
        pix.image_width  = width_reg;
        pix.image_height = height_reg;
        pix.last_result  = 1'b0;

        stat_valid = 1'b0;
        stat.result_kind  = tsg_pkg::KIND_STATUS;
        stat.grey_value   = '0;
        stat.pixel_column = '0;
        stat.pixel_row    = '0;
        stat.status_code  = tsg_pkg::ST_OK;
        stat.image_width  = width_reg;
        stat.image_height = height_reg;
        stat.last_result  = 1'b1;
        if (accept)
        begin
            if ((phase_reg == tsg_pkg::PH_HEADER) && hdr_last && hdr_done)
            begin
                stat_valid       = 1'b1;
                stat.status_code = hdr_code;
            end
            if ((phase_reg == tsg_pkg::PH_DATA) && data_finish)
            begin
                stat_valid = 1'b1;
            end
            if (eof)
            begin
                if (phase_after == tsg_pkg::PH_HEADER)
                begin
                    stat_valid        = 1'b1;
                    stat.status_code  = tsg_pkg::ST_TOO_SHORT;
                    stat.image_width  = '0;
                    stat.image_height = '0;
                end
                else if ((phase_after == tsg_pkg::PH_SKIP)
                         || (phase_after == tsg_pkg::PH_DATA))
                begin
                    stat_valid       = 1'b1;
                    stat.status_code = tsg_pkg::ST_TRUNCATED;
                end
            end
        end

        push.count  = {1'b0, pix_valid} + {1'b0, stat_valid};
        push.first  = pix_valid ? pix : stat;
        push.second = stat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= tsg_pkg::PH_HEADER;
            hdr_count_reg <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            three_reg     <= 1'b0;
            top_reg       <= 1'b0;
            il_reg        <= tsg_pkg::IL_NONE;
            depth_bad_reg <= 1'b0;
            rows_reg      <= '0;
            skip_reg      <= '0;
            out_row_reg   <= '0;
            col_reg       <= '0;
            bip_reg       <= '0;
            blue_reg      <= '0;
            green_reg     <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_count_reg <= hdr_count_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            three_reg     <= three_next;
            top_reg       <= top_next;
            il_reg        <= il_next;
            depth_bad_reg <= depth_bad_next;
            rows_reg      <= rows_next;
            skip_reg      <= skip_next;
            out_row_reg   <= out_row_next;
            col_reg       <= col_next;
            bip_reg       <= bip_next;
            blue_reg      <= blue_next;
            green_reg     <= green_next;
        end
    end

endmodule

@@ hdl/tsg_result_fifo.sv @@
// Small result queue taking up to two results per cycle and giving one when not stalled.
module tsg_result_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  tsg_pkg::push_t   push,
    output logic             valid,
    input  logic             stall,
    output tsg_pkg::result_t data,
    output logic [$clog2(DEPTH+1)-1:0] level,
    output logic             full_for_two
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);

    tsg_pkg::result_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_plus1;
    logic [LVL_W-1:0] level_reg, level_next;
    logic             pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign valid        = (level_reg != '0);
    assign data         = mem[rd_ptr_reg];
    assign pop          = valid && !stall;
    assign level        = level_reg;
    assign full_for_two = (level_reg > LVL_W'(DEPTH - 2));
    assign wr_ptr_plus1 = ptr_inc(wr_ptr_reg);

    always_comb
    begin
        case (push.count)
            2'd1:    wr_ptr_next = wr_ptr_plus1;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_plus1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        level_next  = level_reg + LVL_W'(push.count) - LVL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wr_ptr_plus1] <= push.second;
    end

endmodule

@@ hdl/tga_stream_to_greyscale_core.sv @@
// Top level of the TGA stream to greyscale decoder.
//
// The byte channel (byte_valid, byte_stall, byte_req) carries one request per
// file byte with an end-of-file mark on the last byte of each file. The result
// channel (result_valid, result_stall, result_req) carries grey pixels with
// their mapped column and row, and one final status request per file.
// The APB-style port holds the row window: first_row at address 0 and end_row at
// address 4; the user must write it only while the block is idle (not enforced).
//
// Each accepted byte is decoded in the cycle it is taken, and its results are
// written into a small result queue. A result appears on the result channel
// in the cycle after its byte is accepted when the queue is empty. The block
// takes one byte per cycle; a byte can yield up to two results, and byte_stall
// rises whenever the queue has fewer than two free entries, so the sustained
// rate is one byte per cycle as long as the receiver takes one result per cycle.
// When the receiver stalls, results wait in the queue and, once it is nearly
// full, the byte channel is stalled; nothing is lost or dropped.
// Reset sets the window to the whole image and waits for a file header; there
// is no clearing pass.
module tga_stream_to_greyscale_core #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       byte_valid,
    output logic                       byte_stall,
    input  tsg_pkg::byte_t             byte_req,
    output logic                       result_valid,
    input  logic                       result_stall,
    output tsg_pkg::result_t           result_req,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tsg_pkg::ADDR_W-1:0] paddr,
    input  logic [tsg_pkg::DATA_W-1:0] pwdata,
    output logic [tsg_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    tsg_pkg::cfg_t  cfg;
    tsg_pkg::push_t push;
    logic           accept;
    logic [$clog2(FIFO_DEPTH+1)-1:0] level;

    // A byte is taken whenever the queue can absorb the worst case of two results.
    assign accept = byte_valid && !byte_stall;

    tsg_config u_config (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tsg_decoder u_decoder (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (byte_req),
        .cfg    (cfg),
        .push   (push)
    );

    tsg_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .valid        (result_valid),
        .stall        (result_stall),
        .data         (result_req),
        .level        (level),
        .full_for_two (byte_stall)
    );

    // The queue never holds more results than it has entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        level <= ($clog2(FIFO_DEPTH+1))'(FIFO_DEPTH))
        else $error("result queue overflow");

    // A status request is always the last one of its file, and a pixel never is.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_req.last_result == result_req.result_kind))
        else $error("last_result does not match result kind");

    // Pixels carry an ok status code.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_req.result_kind == tsg_pkg::KIND_PIXEL))
        |-> (result_req.status_code == tsg_pkg::ST_OK))
        else $error("pixel request with nonzero status");

    // An accepted byte that produces results makes the queue nonempty next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |=> result_valid)
        else $error("pushed result not visible");

endmodule
